FILE: rtl/stma_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stma_pkg
// Shared types and codes for the sparse triplet matrix add core.
// ----------------------------------------------------------------------------
package stma_pkg;

  // default sizes
  localparam int MAX_TERMS_DEF  = 32;
  localparam int INDEX_BITS_DEF = 12;
  localparam int VALUE_BITS_DEF = 32;

  // fixed port widths
  localparam int CMD_W      = 2;
  localparam int STATUS_W   = 2;
  localparam int IN_IDX_W   = 12;
  localparam int IN_VAL_W   = 32;
  localparam int DIM_W      = 13;
  localparam int CFG_ADDR_W = 2;

  // input command codes
  localparam logic [CMD_W-1:0] CMD_LOAD_A = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_B = 2'd1;
  localparam logic [CMD_W-1:0] CMD_START  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_ENTRY    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISMATCH = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_A_ROWS = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_A_COLS = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_B_ROWS = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_B_COLS = 2'd3;

  // classified operation handed from front to back
  typedef enum logic [1:0] {
    OP_LOAD_A,
    OP_LOAD_B,
    OP_START,
    OP_CLEAR
  } op_t;

  // back end sequencer
  typedef enum logic {
    B_IDLE,
    B_MERGE
  } bstate_t;

  // queue head control toward the back end
  typedef struct packed {
    logic valid;
    op_t  op;
  } qctl_t;

endpackage
`default_nettype wire

FILE: rtl/stma_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stma_front
// Accepts input items, decodes the command and queues them for the back end
// in a two-entry queue.
// ----------------------------------------------------------------------------
module stma_front #(
  parameter int INDEX_BITS = 12,
  parameter int VALUE_BITS = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [stma_pkg::CMD_W-1:0]     cmd,
  input  wire logic [stma_pkg::IN_IDX_W-1:0]  entry_row,
  input  wire logic [stma_pkg::IN_IDX_W-1:0]  entry_col,
  input  wire logic signed [stma_pkg::IN_VAL_W-1:0] entry_value,
  output stma_pkg::qctl_t                     q_ctl,
  input  wire logic                           q_ready,
  output logic [INDEX_BITS-1:0]               q_row,
  output logic [INDEX_BITS-1:0]               q_col,
  output logic signed [VALUE_BITS-1:0]        q_value
);
  import stma_pkg::*;

  op_t                          fifo_op    [2];
  logic [INDEX_BITS-1:0]        fifo_row   [2];
  logic [INDEX_BITS-1:0]        fifo_col   [2];
  logic signed [VALUE_BITS-1:0] fifo_value [2];
  logic                         wr_ptr;
  logic                         rd_ptr;
  logic [1:0]                   fill;

  op_t  in_op;
  logic push;
  logic pop;

  // classify the command
  always_comb begin
    case (cmd)
      CMD_LOAD_A: in_op = OP_LOAD_A;
      CMD_LOAD_B: in_op = OP_LOAD_B;
      CMD_START:  in_op = OP_START;
      CMD_CLEAR:  in_op = OP_CLEAR;
      default:    in_op = OP_CLEAR;
    endcase
  end

  assign in_ready = (fill != 2'd2);
  assign push     = in_valid && in_ready;
  assign pop      = q_ctl.valid && q_ready;

  // queue head
  assign q_ctl.valid = (fill != 2'd0);
  assign q_ctl.op    = fifo_op[rd_ptr];
  assign q_row       = fifo_row[rd_ptr];
  assign q_col       = fifo_col[rd_ptr];
  assign q_value     = fifo_value[rd_ptr];

  // queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      if (push && !pop)      fill <= fill + 2'd1;
      else if (pop && !push) fill <= fill - 2'd1;
    end
  end

  // queue storage; values are taken at the working width, sign-extended
  always_ff @(posedge clk) begin
    if (push) begin
      fifo_op[wr_ptr]    <= in_op;
      fifo_row[wr_ptr]   <= INDEX_BITS'(entry_row);
      fifo_col[wr_ptr]   <= INDEX_BITS'(entry_col);
      fifo_value[wr_ptr] <= VALUE_BITS'(entry_value);
    end
  end

endmodule
`default_nettype wire

FILE: rtl/stma_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stma_back
// Holds both triplet lists, carries out loads and clears, and merges the
// lists on a start, one merge step per cycle into the output register while the output is free.
// ----------------------------------------------------------------------------
module stma_back #(
  parameter int MAX_TERMS  = 32,
  parameter int INDEX_BITS = 12,
  parameter int VALUE_BITS = 32
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire stma_pkg::qctl_t                      q_ctl,
  output logic                                      q_ready,
  input  wire logic [INDEX_BITS-1:0]                q_row,
  input  wire logic [INDEX_BITS-1:0]                q_col,
  input  wire logic signed [VALUE_BITS-1:0]         q_value,
  input  wire logic                                 dim_mismatch,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic [stma_pkg::STATUS_W-1:0]             status,
  output logic [stma_pkg::IN_IDX_W-1:0]             out_row,
  output logic [stma_pkg::IN_IDX_W-1:0]             out_col,
  output logic signed [stma_pkg::IN_VAL_W-1:0]      out_value,
  output logic                                      last,
  output logic                                      dropped
);
  import stma_pkg::*;

  localparam int CNT_W = $clog2(MAX_TERMS + 1);
  localparam int PTR_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam logic signed [VALUE_BITS-1:0] VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic signed [VALUE_BITS-1:0] VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

  // list storage
  logic [INDEX_BITS-1:0]        a_row_mem [MAX_TERMS];
  logic [INDEX_BITS-1:0]        a_col_mem [MAX_TERMS];
  logic signed [VALUE_BITS-1:0] a_val_mem [MAX_TERMS];
  logic [INDEX_BITS-1:0]        b_row_mem [MAX_TERMS];
  logic [INDEX_BITS-1:0]        b_col_mem [MAX_TERMS];
  logic signed [VALUE_BITS-1:0] b_val_mem [MAX_TERMS];

  logic [CNT_W-1:0] a_count;
  logic [CNT_W-1:0] b_count;
  logic             drop_flag;
  logic [CNT_W-1:0] i;
  logic [CNT_W-1:0] j;
  logic [CNT_W-1:0] i_next;
  logic [CNT_W-1:0] j_next;

  bstate_t state;
  bstate_t state_next;

  // pending result, sent once it is known whether another follows
  logic                         hold_valid;
  logic [INDEX_BITS-1:0]        hold_row;
  logic [INDEX_BITS-1:0]        hold_col;
  logic signed [VALUE_BITS-1:0] hold_value;

  // merge step datapath
  logic                         a_has;
  logic                         b_has;
  logic [INDEX_BITS-1:0]        ra;
  logic [INDEX_BITS-1:0]        ca;
  logic signed [VALUE_BITS-1:0] va;
  logic [INDEX_BITS-1:0]        rb;
  logic [INDEX_BITS-1:0]        cb;
  logic signed [VALUE_BITS-1:0] vb;
  logic                         take_a;
  logic                         take_b;
  logic signed [VALUE_BITS:0]   wide_sum;
  logic signed [VALUE_BITS-1:0] sat_sum;
  logic                         step_emit;
  logic [INDEX_BITS-1:0]        step_row;
  logic [INDEX_BITS-1:0]        step_col;
  logic signed [VALUE_BITS-1:0] step_value;
  logic                         merge_done;

  // control
  logic                         out_free;
  logic                         step_go;
  logic                         do_push;
  logic [STATUS_W-1:0]          push_status;
  logic [INDEX_BITS-1:0]        push_row;
  logic [INDEX_BITS-1:0]        push_col;
  logic signed [VALUE_BITS-1:0] push_value;
  logic                         push_last;
  logic                         q_take;

  assign out_free = !out_valid || out_ready;

  // compare/add of one merge step on the registered list heads
  always_comb begin
    a_has = (i < a_count);
    b_has = (j < b_count);
    if (a_has && b_has) begin
      take_a = ({ra, ca} <= {rb, cb});
      take_b = ({rb, cb} <= {ra, ca});
    end else begin
      take_a = a_has;
      take_b = !a_has;
    end
    wide_sum = {va[VALUE_BITS-1], va} + {vb[VALUE_BITS-1], vb};
    if (wide_sum[VALUE_BITS] != wide_sum[VALUE_BITS-1]) begin
      sat_sum = wide_sum[VALUE_BITS] ? VAL_MIN : VAL_MAX;
    end else begin
      sat_sum = wide_sum[VALUE_BITS-1:0];
    end
    merge_done = !a_has && !b_has;
    step_row   = take_a ? ra : rb;
    step_col   = take_a ? ca : cb;
    if (take_a && take_b) begin
      step_value = sat_sum;
      step_emit  = (sat_sum != '0);
    end else begin
      step_value = take_a ? va : vb;
      step_emit  = 1'b1;
    end
  end

  // sequencer outputs
  always_comb begin
    q_ready     = 1'b0;
    q_take      = 1'b0;
    step_go     = 1'b0;
    do_push     = 1'b0;
    push_status = ST_ENTRY;
    push_row    = hold_row;
    push_col    = hold_col;
    push_value  = hold_value;
    push_last   = 1'b0;
    case (state)
      B_IDLE: begin
        if (q_ctl.op == OP_START && dim_mismatch) begin
          q_ready = out_free;
        end else begin
          q_ready = 1'b1;
        end
        q_take = q_ctl.valid && q_ready;
        if (q_take && q_ctl.op == OP_START && dim_mismatch) begin
          do_push     = 1'b1;
          push_status = ST_MISMATCH;
          push_row    = '0;
          push_col    = '0;
          push_value  = '0;
          push_last   = 1'b1;
        end
      end
      B_MERGE: begin
        if (merge_done) begin
          if (out_free) begin
            do_push   = 1'b1;
            push_last = 1'b1;
            if (!hold_valid) push_status = ST_EMPTY;
          end
        end else if (step_emit && hold_valid) begin
          step_go = out_free;
          do_push = out_free;
        end else begin
          step_go = 1'b1;
        end
        if (do_push && push_status != ST_ENTRY) begin
          push_row   = '0;
          push_col   = '0;
          push_value = '0;
        end
      end
      default: begin
        q_ready = 1'b0;
      end
    endcase
  end

  // list read pointers for the next step
  always_comb begin
    i_next = i;
    j_next = j;
    if (q_take && q_ctl.op == OP_START) begin
      i_next = '0;
      j_next = '0;
    end else if (step_go) begin
      if (take_a) i_next = i + 1'b1;
      if (take_b) j_next = j + 1'b1;
    end
  end

  // sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (q_take && q_ctl.op == OP_START && !dim_mismatch) state_next = B_MERGE;
      end
      B_MERGE: begin
        if (merge_done && out_free) state_next = B_IDLE;
      end
      default: state_next = B_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_IDLE;
      a_count    <= '0;
      b_count    <= '0;
      drop_flag  <= 1'b0;
      i          <= '0;
      j          <= '0;
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      i     <= i_next;
      j     <= j_next;
      if (q_take) begin
        case (q_ctl.op)
          OP_LOAD_A: begin
            if (a_count == CNT_W'(MAX_TERMS)) drop_flag <= 1'b1;
            else a_count <= a_count + 1'b1;
          end
          OP_LOAD_B: begin
            if (b_count == CNT_W'(MAX_TERMS)) drop_flag <= 1'b1;
            else b_count <= b_count + 1'b1;
          end
          OP_CLEAR: begin
            a_count   <= '0;
            b_count   <= '0;
            drop_flag <= 1'b0;
          end
          OP_START: begin
            hold_valid <= 1'b0;
          end
          default: begin
            drop_flag <= drop_flag;
          end
        endcase
      end
      if (step_go && step_emit) hold_valid <= 1'b1;
      if (do_push)       out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // list storage writes
  always_ff @(posedge clk) begin
    if (q_take && q_ctl.op == OP_LOAD_A && a_count != CNT_W'(MAX_TERMS)) begin
      a_row_mem[a_count[PTR_W-1:0]] <= q_row;
      a_col_mem[a_count[PTR_W-1:0]] <= q_col;
      a_val_mem[a_count[PTR_W-1:0]] <= q_value;
    end
    if (q_take && q_ctl.op == OP_LOAD_B && b_count != CNT_W'(MAX_TERMS)) begin
      b_row_mem[b_count[PTR_W-1:0]] <= q_row;
      b_col_mem[b_count[PTR_W-1:0]] <= q_col;
      b_val_mem[b_count[PTR_W-1:0]] <= q_value;
    end
  end

  // list heads, read at the pointers of the coming step
  always_ff @(posedge clk) begin
    ra <= a_row_mem[i_next[PTR_W-1:0]];
    ca <= a_col_mem[i_next[PTR_W-1:0]];
    va <= a_val_mem[i_next[PTR_W-1:0]];
    rb <= b_row_mem[j_next[PTR_W-1:0]];
    cb <= b_col_mem[j_next[PTR_W-1:0]];
    vb <= b_val_mem[j_next[PTR_W-1:0]];
  end

  // pending result and output register payload
  always_ff @(posedge clk) begin
    if (step_go && step_emit) begin
      hold_row   <= step_row;
      hold_col   <= step_col;
      hold_value <= step_value;
    end
    if (do_push) begin
      status    <= push_status;
      out_row   <= IN_IDX_W'(push_row);
      out_col   <= IN_IDX_W'(push_col);
      out_value <= IN_VAL_W'(push_value);
      last      <= push_last;
      dropped   <= drop_flag;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/sparse_triplet_matrix_add_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sparse_triplet_matrix_add_core
// Sparse matrix addition over two row-major triplet lists.
// ----------------------------------------------------------------------------
// Items enter a two-entry queue and are executed in order. A load or clear
// is carried out in the back end. A start with matching dimensions walks
// both lists, one merge step per cycle, so it takes a_count + b_count steps
// at most before it closes; each result is held until the next one or the
// end is known so the final one can carry last, and the output register lets
// the next step proceed while a result waits. A mismatch start puts its status
// in the output register without a merge. A stalled output stops the merge until the result is taken.
module sparse_triplet_matrix_add_core #(
  parameter int MAX_TERMS  = stma_pkg::MAX_TERMS_DEF,
  parameter int INDEX_BITS = stma_pkg::INDEX_BITS_DEF,
  parameter int VALUE_BITS = stma_pkg::VALUE_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [stma_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  wire logic [stma_pkg::DIM_W-1:0]           cfg_data,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [stma_pkg::CMD_W-1:0]           cmd,
  input  wire logic [stma_pkg::IN_IDX_W-1:0]        entry_row,
  input  wire logic [stma_pkg::IN_IDX_W-1:0]        entry_col,
  input  wire logic signed [stma_pkg::IN_VAL_W-1:0] entry_value,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic [stma_pkg::STATUS_W-1:0]             status,
  output logic [stma_pkg::IN_IDX_W-1:0]             out_row,
  output logic [stma_pkg::IN_IDX_W-1:0]             out_col,
  output logic signed [stma_pkg::IN_VAL_W-1:0]      out_value,
  output logic                                      last,
  output logic                                      dropped
);
  import stma_pkg::*;

  logic [DIM_W-1:0] a_rows;
  logic [DIM_W-1:0] a_cols;
  logic [DIM_W-1:0] b_rows;
  logic [DIM_W-1:0] b_cols;
  logic             dim_mismatch;

  qctl_t                        q_ctl;
  logic                         q_ready;
  logic [INDEX_BITS-1:0]        q_row;
  logic [INDEX_BITS-1:0]        q_col;
  logic signed [VALUE_BITS-1:0] q_value;

  // dimension registers
  always_ff @(posedge clk) begin
    if (rst) begin
      a_rows <= DIM_W'(1);
      a_cols <= DIM_W'(1);
      b_rows <= DIM_W'(1);
      b_cols <= DIM_W'(1);
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_A_ROWS: a_rows <= cfg_data;
        REG_A_COLS: a_cols <= cfg_data;
        REG_B_ROWS: b_rows <= cfg_data;
        REG_B_COLS: b_cols <= cfg_data;
        default:    a_rows <= a_rows;
      endcase
    end
  end

  assign dim_mismatch = (a_rows != b_rows) || (a_cols != b_cols);

  stma_front #(
    .INDEX_BITS (INDEX_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cmd         (cmd),
    .entry_row   (entry_row),
    .entry_col   (entry_col),
    .entry_value (entry_value),
    .q_ctl       (q_ctl),
    .q_ready     (q_ready),
    .q_row       (q_row),
    .q_col       (q_col),
    .q_value     (q_value)
  );

  stma_back #(
    .MAX_TERMS  (MAX_TERMS),
    .INDEX_BITS (INDEX_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_ctl        (q_ctl),
    .q_ready      (q_ready),
    .q_row        (q_row),
    .q_col        (q_col),
    .q_value      (q_value),
    .dim_mismatch (dim_mismatch),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .out_row      (out_row),
    .out_col      (out_col),
    .out_value    (out_value),
    .last         (last),
    .dropped      (dropped)
  );

endmodule
`default_nettype wire

FILE: rtl/stma_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stma_checker
// Port-level checks of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module stma_checker (
  input wire logic                                 clk,
  input wire logic                                 rst,
  input wire logic                                 out_valid,
  input wire logic                                 out_ready,
  input wire logic [stma_pkg::STATUS_W-1:0]        status,
  input wire logic [stma_pkg::IN_IDX_W-1:0]        out_row,
  input wire logic [stma_pkg::IN_IDX_W-1:0]        out_col,
  input wire logic signed [stma_pkg::IN_VAL_W-1:0] out_value,
  input wire logic                                 last,
  input wire logic                                 dropped
);
  import stma_pkg::*;

  // inside a run of entries of one start
  logic mid_run;
  logic run_dropped;

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_run     <= 1'b0;
      run_dropped <= 1'b0;
    end else if (out_valid && out_ready) begin
      mid_run     <= !last;
      run_dropped <= dropped;
    end
  end

  // a status result stands alone with cleared fields
  a_status_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_ENTRY |->
      last && out_row == '0 && out_col == '0 && out_value == '0)
    else $error("status result not alone or fields not cleared");

  // only entries follow a non-final entry
  a_run_entries: assert property (@(posedge clk) disable iff (rst)
    out_valid && mid_run |-> status == ST_ENTRY)
    else $error("status result inside an entry run");

  // the drop flag cannot change inside one start
  a_run_dropped: assert property (@(posedge clk) disable iff (rst)
    out_valid && mid_run |-> dropped == run_dropped)
    else $error("dropped changed within one start");

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      out_valid && $stable(status) && $stable(out_row) && $stable(out_col) &&
      $stable(out_value) && $stable(last) && $stable(dropped))
    else $error("result changed while stalled");

endmodule

bind sparse_triplet_matrix_add_core stma_checker u_stma_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .status    (status),
  .out_row   (out_row),
  .out_col   (out_col),
  .out_value (out_value),
  .last      (last),
  .dropped   (dropped)
);
`default_nettype wire
